// File: hdl/gha_pkg.sv
// Shared types and codes for the generation-tagged handle allocator.
// Used by the top level; no dependencies.
`default_nettype none

package gha_pkg;

   localparam int GEN_W   = 32;
   localparam int INDEX_W = 8;
   localparam int DATA_W  = INDEX_W + GEN_W;   // 40 bits, whole bytes

   // request kinds carried on tuser
   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_POP   = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

endpackage : gha_pkg

`default_nettype wire

// File: hdl/gha_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module gha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : gha_ram

`default_nettype wire

// File: hdl/generational_handle_allocator_top.sv
// Generation-tagged handle allocator: control FSM, counters and two RAMs.
// Depends on gha_pkg and gha_ram.
`default_nettype none

// Usage
//   req channel: tuser[0] is the kind (0 allocate, 1 release); tdata carries
//   handle_index in [7:0] and handle_gen in [39:8] (ignored on allocate).
//   rsp channel: one response per request; tuser[1:0] is the status
//   (0 success, 1 table full, 2 release rejected), tdata carries out_index in
//   [7:0] and out_gen in [39:8], both zero unless an allocation succeeded.
// Sequencing
//   One request is in work at a time. On the way from accept to the response
//   register, an allocate that pops the free stack passes ST_POP and ST_FETCH
//   (stack read, then generation table read), a release that reaches the
//   table check passes ST_CHECK, and a fresh allocate, a full table or an
//   early reject go straight to ST_RESP. The next request is taken once the
//   FSM is back in ST_IDLE; the stack and table RAMs have registered reads.
// Reset
//   Clears the FSM, the free-stack depth, the used extent and rsp_tvalid.
//   RAM contents are not cleared; entries are read only after being written.
// Stall
//   The response sits in an output register; while the receiver stalls the
//   next request is still accepted and worked up to its own response, which
//   waits until the register is free.
module generational_handle_allocator_top #(
   parameter int HANDLE_CAPACITY = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [gha_pkg::DATA_W-1:0]  req_tdata,   // handle_index, handle_gen
   input  wire logic [0:0]                  req_tuser,   // kind
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [gha_pkg::DATA_W-1:0]  rsp_tdata,   // out_index, out_gen
   output logic      [1:0]                  rsp_tuser    // status
);

   localparam int IW    = $clog2(HANDLE_CAPACITY);
   localparam int CW    = $clog2(HANDLE_CAPACITY + 1);
   localparam int CMP_W = (CW > gha_pkg::INDEX_W) ? CW : gha_pkg::INDEX_W;
   localparam int TAB_W = gha_pkg::GEN_W + 1;           // {alive, generation}
   localparam logic [CW-1:0] CAP_C = CW'(HANDLE_CAPACITY);

   gha_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      free_ff, free_in;
   logic [CW-1:0]      used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]               idx_ff, idx_in;
   logic [gha_pkg::GEN_W-1:0]   gen_ff, gen_in;
   gha_pkg::status_type         res_status_ff, res_status_in;
   logic [gha_pkg::INDEX_W-1:0] res_index_ff, res_index_in;
   logic [gha_pkg::GEN_W-1:0]   res_gen_ff, res_gen_in;
   gha_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [gha_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [gha_pkg::GEN_W-1:0]   rsp_gen_ff, rsp_gen_in;

   logic              tab_wr_en, tab_rd_en;
   logic [IW-1:0]     tab_wr_addr, tab_rd_addr;
   logic [TAB_W-1:0]  tab_wr_data, tab_rd_data;
   logic              stk_wr_en, stk_rd_en;
   logic [IW-1:0]     stk_wr_addr, stk_rd_addr, stk_rd_data;

   logic                        req_fire;
   logic [gha_pkg::INDEX_W-1:0] req_index;
   logic [gha_pkg::GEN_W-1:0]   req_gen;
   logic [CW-1:0]               free_dec;
   logic                        rsp_free;

   assign req_index  = req_tdata[gha_pkg::INDEX_W-1:0];
   assign req_gen    = req_tdata[gha_pkg::DATA_W-1:gha_pkg::INDEX_W];
   assign req_tready = (state_ff == gha_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign free_dec   = free_ff - CW'(1);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_gen_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

   gha_ram #(.WIDTH(TAB_W), .DEPTH(HANDLE_CAPACITY)) u_gen_table (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_data),
      .rd_en   (tab_rd_en),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   gha_ram #(.WIDTH(IW), .DEPTH(HANDLE_CAPACITY)) u_free_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (idx_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff;
      idx_in        = idx_ff;
      gen_in        = gen_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_gen_in    = res_gen_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_gen_in    = rsp_gen_ff;
      tab_wr_en     = 1'b0;
      tab_wr_addr   = idx_ff;
      tab_wr_data   = {1'b1, gha_pkg::GEN_W'(1)};
      tab_rd_en     = 1'b0;
      tab_rd_addr   = idx_ff;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = free_ff[IW-1:0];
      stk_rd_en     = 1'b0;
      stk_rd_addr   = free_dec[IW-1:0];

      // drop the response once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         gha_pkg::ST_IDLE: begin
            if (req_fire) begin
               idx_in        = IW'(req_index);
               gen_in        = req_gen;
               res_status_in = gha_pkg::STATUS_OK;
               res_index_in  = '0;
               res_gen_in    = '0;
               state_in      = gha_pkg::ST_RESP;
               if (req_tuser[0] == gha_pkg::KIND_ALLOC) begin
                  if (free_ff != '0) begin
                     stk_rd_en = 1'b1;
                     free_in   = free_dec;
                     state_in  = gha_pkg::ST_POP;
                  end else if (used_ff < CAP_C) begin
                     // fresh index starts alive at generation 1
                     tab_wr_en    = 1'b1;
                     tab_wr_addr  = used_ff[IW-1:0];
                     res_index_in = gha_pkg::INDEX_W'(used_ff[IW-1:0]);
                     res_gen_in   = gha_pkg::GEN_W'(1);
                     used_in      = used_ff + CW'(1);
                  end else begin
                     res_status_in = gha_pkg::STATUS_FULL;
                  end
               end else begin
                  if (req_gen == '0 || CMP_W'(req_index) >= CMP_W'(used_ff)) begin
                     res_status_in = gha_pkg::STATUS_REJECT;
                  end else begin
                     tab_rd_en   = 1'b1;
                     tab_rd_addr = IW'(req_index);
                     state_in    = gha_pkg::ST_CHECK;
                  end
               end
            end
         end
         gha_pkg::ST_POP: begin
            idx_in      = stk_rd_data;
            tab_rd_en   = 1'b1;
            tab_rd_addr = stk_rd_data;
            state_in    = gha_pkg::ST_FETCH;
         end
         gha_pkg::ST_FETCH: begin
            // mark alive, keep the stored generation
            tab_wr_en    = 1'b1;
            tab_wr_data  = {1'b1, tab_rd_data[gha_pkg::GEN_W-1:0]};
            res_index_in = gha_pkg::INDEX_W'(idx_ff);
            res_gen_in   = tab_rd_data[gha_pkg::GEN_W-1:0];
            state_in     = gha_pkg::ST_RESP;
         end
         gha_pkg::ST_CHECK: begin
            if (tab_rd_data[gha_pkg::GEN_W] && tab_rd_data[gha_pkg::GEN_W-1:0] == gen_ff) begin
               tab_wr_en   = 1'b1;
               tab_wr_data = {1'b0, tab_rd_data[gha_pkg::GEN_W-1:0] + gha_pkg::GEN_W'(1)};
               if (free_ff < CAP_C) begin
                  stk_wr_en = 1'b1;
                  free_in   = free_ff + CW'(1);
               end
            end else begin
               res_status_in = gha_pkg::STATUS_REJECT;
            end
            state_in = gha_pkg::ST_RESP;
         end
         gha_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_gen_in    = res_gen_ff;
               state_in      = gha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gha_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gha_pkg::ST_IDLE;
         free_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      gen_ff        <= gen_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_gen_ff    <= res_gen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_gen_ff    <= rsp_gen_in;
   end

   a_depth_le_extent: assert property (@(posedge clock) disable iff (reset)
      free_ff <= used_ff)
      else $error("free stack deeper than used extent");

   a_full_only_when_exhausted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gha_pkg::ST_RESP && res_status_ff == gha_pkg::STATUS_FULL)
      |-> (used_ff == CAP_C && free_ff == '0))
      else $error("full reported with free indices left");

   a_request_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != gha_pkg::ST_IDLE)
      else $error("request accepted without work state");

   a_fail_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != gha_pkg::STATUS_OK)
      |-> (rsp_index_ff == '0 && rsp_gen_ff == '0))
      else $error("failed response carries a handle");

endmodule : generational_handle_allocator_top

`default_nettype wire
